[src/apu_nonlinear_mixer_top_macros.svh]
// ----------------------------------------------------------------------------
// APU nonlinear mixer assertion macros
// Shared concurrent assertion forms for the mixer modules.
// ----------------------------------------------------------------------------
`ifndef APU_NONLINEAR_MIXER_TOP_MACROS_SVH
`define APU_NONLINEAR_MIXER_TOP_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define AMIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define AMIX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/amix_pkg.sv]
// ----------------------------------------------------------------------------
// APU nonlinear mixer package
// Widths, mixing constants and the divider request type shared by the mixer.
// ----------------------------------------------------------------------------
package amix_pkg;

  // Output format and divider length.
  localparam int OUT_FRAC_BITS = 16;
  localparam int GUARD_BITS    = 16;
  localparam int QBITS         = OUT_FRAC_BITS + GUARD_BITS;
  localparam int MIX_W         = 16;
  localparam logic [MIX_W-1:0] MIX_MAX = '1;

  // Field widths.
  localparam int LVL_W  = 4;
  localparam int DLT_W  = 7;
  localparam int MASK_W = 5;
  localparam int SUM_W  = 5;
  localparam int N_W    = 35;
  localparam int P_W    = 21;
  localparam int T_W    = 49;
  localparam int K_W    = 29;
  localparam int G_W    = 14;

  // Mute mask bit positions.
  localparam int MUTE_P1  = 0;
  localparam int MUTE_P2  = 1;
  localparam int MUTE_TRI = 2;
  localparam int MUTE_NSE = 3;
  localparam int MUTE_DLT = 4;

  // Pulse part: 9588*s / (812800 + 10000*s).
  localparam logic [G_W-1:0] PULSE_GAIN = 14'd9588;
  localparam logic [P_W-1:0] PULSE_BASE = 21'd812800;
  localparam logic [G_W-1:0] MIX_SCALE  = 14'd10000;

  // Triangle/noise/delta part: 15979*N / (100*D + 10000*N).
  localparam logic [G_W-1:0] TND_GAIN = 14'd15979;
  localparam logic [K_W-1:0] K_TRI    = 29'd277111758;
  localparam logic [K_W-1:0] K_NOISE  = 29'd186242826;
  localparam logic [K_W-1:0] K_DELTA  = 29'd100706707;
  localparam logic [T_W-1:0] T_BASE   = 49'd227979843306600;

  // One request travelling down the divider chain.
  typedef struct packed {
    logic             valid;
    logic             block_end;
    logic [P_W-1:0]   p_rem;
    logic [P_W-1:0]   p_den;
    logic [QBITS-1:0] p_q;
    logic [T_W-1:0]   t_rem;
    logic [T_W-1:0]   t_den;
    logic [QBITS-1:0] t_q;
  } amix_div_t;

endpackage

[src/amix_prep.sv]
// ----------------------------------------------------------------------------
// APU nonlinear mixer front end
// Applies the mute mask and builds both numerator/denominator pairs in two
// registered stages.
// ----------------------------------------------------------------------------
module amix_prep
  import amix_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [LVL_W-1:0]  pulse_one,
  input  logic [LVL_W-1:0]  pulse_two,
  input  logic [LVL_W-1:0]  triangle_level,
  input  logic [LVL_W-1:0]  noise_level,
  input  logic [DLT_W-1:0]  delta_level,
  input  logic              block_end,
  input  logic [MASK_W-1:0] mute_mask,
  output amix_div_t         div_o
);

  logic [LVL_W-1:0] p1_m, p2_m, tri_m, nse_m;
  logic [DLT_W-1:0] dlt_m;
  logic [SUM_W-1:0] s_nxt;
  logic [N_W-1:0]   n_nxt;

  logic             a_valid_r;
  logic             a_be_r;
  logic [SUM_W-1:0] a_s_r;
  logic [N_W-1:0]   a_n_r;

  amix_div_t b_nxt;
  amix_div_t b_r;

  // A muted channel reads as level zero.
  always_comb begin
    p1_m  = mute_mask[MUTE_P1]  ? '0 : pulse_one;
    p2_m  = mute_mask[MUTE_P2]  ? '0 : pulse_two;
    tri_m = mute_mask[MUTE_TRI] ? '0 : triangle_level;
    nse_m = mute_mask[MUTE_NSE] ? '0 : noise_level;
    dlt_m = mute_mask[MUTE_DLT] ? '0 : delta_level;
  end

  // Pulse sum and the weighted triangle/noise/delta numerator.
  always_comb begin
    s_nxt = SUM_W'(p1_m) + SUM_W'(p2_m);
    n_nxt = N_W'(tri_m) * N_W'(K_TRI) + N_W'(nse_m) * N_W'(K_NOISE)
          + N_W'(dlt_m) * N_W'(K_DELTA);
  end

  // First stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      a_be_r    <= block_end;
      a_s_r     <= s_nxt;
      a_n_r     <= n_nxt;
    end
  end

  // Scale into the two fractions; the quotients start empty.
  always_comb begin
    b_nxt.valid     = a_valid_r;
    b_nxt.block_end = a_be_r;
    b_nxt.p_rem     = P_W'(PULSE_GAIN) * P_W'(a_s_r);
    b_nxt.p_den     = PULSE_BASE + P_W'(MIX_SCALE) * P_W'(a_s_r);
    b_nxt.p_q       = '0;
    b_nxt.t_rem     = T_W'(TND_GAIN) * T_W'(a_n_r);
    b_nxt.t_den     = T_BASE + T_W'(MIX_SCALE) * T_W'(a_n_r);
    b_nxt.t_q       = '0;
  end

  // Second stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r <= b_nxt;
    end
  end

  assign div_o = b_r;

endmodule

[src/amix_cell.sv]
// ----------------------------------------------------------------------------
// APU nonlinear mixer divider cell
// One restoring division step for the pulse and the tnd fractions.
// ----------------------------------------------------------------------------
`include "apu_nonlinear_mixer_top_macros.svh"

module amix_cell
  import amix_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  amix_div_t div_i,
  output amix_div_t div_o
);

  logic [P_W:0] p_sh;
  logic [T_W:0] t_sh;
  logic         p_ge;
  logic         t_ge;
  amix_div_t    cell_nxt;
  amix_div_t    cell_r;

  // Shift the remainder, subtract the divisor when it fits, record the bit.
  always_comb begin
    p_sh = {div_i.p_rem, 1'b0};
    t_sh = {div_i.t_rem, 1'b0};
    p_ge = (p_sh >= {1'b0, div_i.p_den});
    t_ge = (t_sh >= {1'b0, div_i.t_den});

    cell_nxt       = div_i;
    cell_nxt.p_rem = p_ge ? P_W'(p_sh - {1'b0, div_i.p_den}) : P_W'(p_sh);
    cell_nxt.t_rem = t_ge ? T_W'(t_sh - {1'b0, div_i.t_den}) : T_W'(t_sh);
    cell_nxt.p_q   = {div_i.p_q[QBITS-2:0], p_ge};
    cell_nxt.t_q   = {div_i.t_q[QBITS-2:0], t_ge};
  end

  // Hand the request to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign div_o = cell_r;

  // The remainders stay below their divisors after every step, and the tnd divisor never falls below T_BASE.
  `AMIX_ASSERT(a_p_rem_bound, cell_r.valid |-> (cell_r.p_rem < cell_r.p_den), "pulse remainder out of range")
  `AMIX_ASSERT(a_t_rem_bound, cell_r.valid |-> (cell_r.t_rem < cell_r.t_den), "tnd remainder out of range")
  `AMIX_ASSERT(a_t_den_floor, cell_r.valid |-> (cell_r.t_den >= T_BASE), "tnd divisor below its base")

endmodule

[src/amix_out.sv]
// ----------------------------------------------------------------------------
// APU nonlinear mixer output stage
// Adds both fractions, rounds and saturates, and buffers results in an
// output register with one skid entry.
// ----------------------------------------------------------------------------
`include "apu_nonlinear_mixer_top_macros.svh"

module amix_out
  import amix_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  amix_div_t        div_i,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [MIX_W-1:0] out_mix_value,
  output logic             out_block_end_out
);

  localparam logic [QBITS:0] HALF = (QBITS+1)'(1) << (GUARD_BITS - 1);

  logic [QBITS:0]         total;
  logic [QBITS:0]         rnd;
  logic [OUT_FRAC_BITS:0] mix_full;
  logic [MIX_W-1:0]       mix;
  logic                   arrive;
  logic                   take;

  logic             main_valid_r;
  logic [MIX_W-1:0] main_mix_r;
  logic             main_be_r;
  logic             skid_valid_r;
  logic [MIX_W-1:0] skid_mix_r;
  logic             skid_be_r;

  // Sum the two parts, round half up and clip at full scale.
  always_comb begin
    total    = (QBITS+1)'(div_i.p_q) + (QBITS+1)'(div_i.t_q);
    rnd      = total + HALF;
    mix_full = rnd[QBITS:GUARD_BITS];
    if (mix_full > (OUT_FRAC_BITS+1)'(MIX_MAX)) begin
      mix = MIX_MAX;
    end else begin
      mix = MIX_W'(mix_full);
    end
  end

  // The chain moves only while the skid entry is free.
  assign adv    = !skid_valid_r;
  assign arrive = adv && div_i.valid;
  assign take   = main_valid_r && !out_stall;

  // Output register and skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        main_mix_r   <= skid_mix_r;
        main_be_r    <= skid_be_r;
        skid_valid_r <= 1'b0;
      end
    end else if (arrive) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
        main_mix_r   <= mix;
        main_be_r    <= div_i.block_end;
      end else begin
        skid_valid_r <= 1'b1;
        skid_mix_r   <= mix;
        skid_be_r    <= div_i.block_end;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  assign out_valid         = main_valid_r;
  assign out_mix_value     = main_mix_r;
  assign out_block_end_out = main_be_r;

  // The skid entry is used only behind a held output register; both are empty after reset.
  `AMIX_ASSERT(a_skid_behind_main, skid_valid_r |-> main_valid_r, "skid entry full with empty output")
  `AMIX_ASSERT(a_skid_fill, $rose(skid_valid_r) |-> $past(main_valid_r && out_stall), "skid filled without a stalled output")
  `AMIX_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!main_valid_r && !skid_valid_r), "output not empty after reset")

endmodule

[src/apu_nonlinear_mixer_top.sv]
// ----------------------------------------------------------------------------
// APU nonlinear mixer
// Mixes pulse, triangle, noise and delta levels into one 16-bit amplitude.
// ----------------------------------------------------------------------------
// The mixer takes one sample request per clock while in_stall is low and
// returns one result per request, in order. A request passes through two
// front-end stages that mute and scale the levels, a chain of 32 divider
// cells that each produce one quotient bit of both fractions, and the output
// register. Throughput is one sample per cycle while in_stall is low, set by
// the one restoring step each cell does per clock. A result that waits on
// out_stall parks in the output register while one more request drains into
// a skid entry; in_stall rises only while that skid entry is full. The mute
// mask is written through cfg_wr_en and cfg_wr_data and clears to zero on
// reset.
module apu_nonlinear_mixer_top
  import amix_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [MASK_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [LVL_W-1:0]  in_pulse_one,
  input  logic [LVL_W-1:0]  in_pulse_two,
  input  logic [LVL_W-1:0]  in_triangle_level,
  input  logic [LVL_W-1:0]  in_noise_level,
  input  logic [DLT_W-1:0]  in_delta_level,
  input  logic              in_block_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MIX_W-1:0]  out_mix_value,
  output logic              out_block_end_out
);

  logic [MASK_W-1:0] mute_mask_r;
  logic              adv;
  amix_div_t         chain [QBITS+1];

  // Mute mask register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_mask_r <= '0;
    end else if (cfg_wr_en) begin
      mute_mask_r <= cfg_wr_data;
    end
  end

  assign in_stall = !adv;

  // Front end: mute, sums and fraction setup.
  amix_prep u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .pulse_one      (in_pulse_one),
    .pulse_two      (in_pulse_two),
    .triangle_level (in_triangle_level),
    .noise_level    (in_noise_level),
    .delta_level    (in_delta_level),
    .block_end      (in_block_end),
    .mute_mask      (mute_mask_r),
    .div_o          (chain[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    amix_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .div_i (chain[i]),
      .div_o (chain[i+1])
    );
  end

  // Rounding, saturation and output buffering.
  amix_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .div_i             (chain[QBITS]),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mix_value     (out_mix_value),
    .out_block_end_out (out_block_end_out)
  );

endmodule

[dv/apu_nonlinear_mixer_top_tb.sv]
// ----------------------------------------------------------------------------
// APU nonlinear mixer testbench
// Drives sample requests into the mixer under several mute masks and idling
// patterns, predicts each mixed amplitude bit for bit in an in-order queue,
// and checks every result that the mixer returns against that queue.
// ----------------------------------------------------------------------------
module apu_nonlinear_mixer_top_tb;
  import amix_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = 35;
  localparam int N_DIRECTED   = 23;
  localparam int N_PHASES     = 5;
  localparam int SUBS_PER_PH  = 5;
  localparam int ITEMS_PER_SUB = 70;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_REPORTS  = 10;

  // One sample request as the channel carries it.
  typedef struct packed {
    logic [LVL_W-1:0] p1;
    logic [LVL_W-1:0] p2;
    logic [LVL_W-1:0] tri_lvl;
    logic [LVL_W-1:0] nse_lvl;
    logic [DLT_W-1:0] dlt_lvl;
    logic             blk_end;
  } sample_t;

  // One mixed result as the output channel carries it.
  typedef struct packed {
    logic [MIX_W-1:0] mix;
    logic             blk_end;
  } mix_rec_t;

  // One row of the directed table; a typed row carries its own answer.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    sample_t           smp;
    logic              typed;
    logic [MIX_W-1:0]  mix;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [MASK_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [LVL_W-1:0]  in_pulse_one;
  logic [LVL_W-1:0]  in_pulse_two;
  logic [LVL_W-1:0]  in_triangle_level;
  logic [LVL_W-1:0]  in_noise_level;
  logic [DLT_W-1:0]  in_delta_level;
  logic              in_block_end;
  logic              out_valid;
  logic              out_stall;
  logic [MIX_W-1:0]  out_mix_value;
  logic              out_block_end_out;

  mix_rec_t          pending_mixes[$];
  logic [MASK_W-1:0] mute_shadow;
  dir_row_t          dir_rows [N_DIRECTED];
  int                idle_pct;
  int                stall_pct;
  int                hold_tokens;
  int                samples_sent;
  int                mixes_checked;
  int                mismatch_count;
  int                mask_writes;

  apu_nonlinear_mixer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pulse_one      (in_pulse_one),
    .in_pulse_two      (in_pulse_two),
    .in_triangle_level (in_triangle_level),
    .in_noise_level    (in_noise_level),
    .in_delta_level    (in_delta_level),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mix_value     (out_mix_value),
    .out_block_end_out (out_block_end_out)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Backstop against a hung handshake.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // floor(num * 2^QBITS / den) for num < den, one restoring step per bit.
  function automatic logic [63:0] frac_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    int          i;
    rem = num;
    quo = '0;
    if (den == 0 || num >= den) return '0;
    for (i = 0; i < QBITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Nonlinear mix of one sample under a given mute mask.
  function automatic mix_rec_t predict_mix(logic [MASK_W-1:0] mask, sample_t s);
    logic [63:0] lp1, lp2, ltri, lnse, ldlt;
    logic [63:0] pulse_lvl_sum, tnd_sum, pulse_q, tnd_q, total, rounded;
    mix_rec_t    res;
    lp1  = mask[MUTE_P1]  ? 64'd0 : 64'(s.p1);
    lp2  = mask[MUTE_P2]  ? 64'd0 : 64'(s.p2);
    ltri = mask[MUTE_TRI] ? 64'd0 : 64'(s.tri_lvl);
    lnse = mask[MUTE_NSE] ? 64'd0 : 64'(s.nse_lvl);
    ldlt = mask[MUTE_DLT] ? 64'd0 : 64'(s.dlt_lvl);
    pulse_q = '0;
    tnd_q   = '0;
    // A silent part adds exactly zero.
    pulse_lvl_sum = lp1 + lp2;
    if (pulse_lvl_sum != 0)
      pulse_q = frac_quotient(64'(PULSE_GAIN) * pulse_lvl_sum,
                              64'(PULSE_BASE) + 64'(MIX_SCALE) * pulse_lvl_sum);
    tnd_sum = ltri * 64'(K_TRI) + lnse * 64'(K_NOISE) + ldlt * 64'(K_DELTA);
    if (tnd_sum != 0)
      tnd_q = frac_quotient(64'(TND_GAIN) * tnd_sum,
                            64'(T_BASE) + 64'(MIX_SCALE) * tnd_sum);
    // Round half up on the guard bits, then clamp at full scale.
    total   = pulse_q + tnd_q;
    rounded = (total + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    res.mix     = (rounded > 64'(MIX_MAX)) ? MIX_MAX : rounded[MIX_W-1:0];
    res.blk_end = s.blk_end;
    return res;
  endfunction

  // Level with extra weight on zero and full scale.
  function automatic logic [7:0] pick_level(int max_lvl);
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'(max_lvl);
      default: return 8'($urandom_range(max_lvl));
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.p1      = LVL_W'(pick_level(15));
    s.p2      = LVL_W'(pick_level(15));
    s.tri_lvl = LVL_W'(pick_level(15));
    s.nse_lvl = LVL_W'(pick_level(15));
    s.dlt_lvl = DLT_W'(pick_level(127));
    s.blk_end = ($urandom_range(3) == 0);
    return s;
  endfunction

  // Wait until every issued request has produced its result, or the limit runs out.
  task automatic drain_results(int limit);
    int waited;
    waited = 0;
    while (pending_mixes.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // The mask only changes while nothing is in flight; a request still on
  // offer is withdrawn first so that it is not taken again.
  task automatic write_mute_mask(logic [MASK_W-1:0] mask);
    @(negedge clk);
    in_valid <= 1'b0;
    drain_results(DRAIN_LIMIT);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    mute_shadow = mask;
    mask_writes++;
  endtask

  // Offer one request, idling first at random, and record its expected mix.
  task automatic issue_sample(sample_t s, logic typed, logic [MIX_W-1:0] typed_mix);
    mix_rec_t want;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_pulse_one      <= s.p1;
    in_pulse_two      <= s.p2;
    in_triangle_level <= s.tri_lvl;
    in_noise_level    <= s.nse_lvl;
    in_delta_level    <= s.dlt_lvl;
    in_block_end      <= s.blk_end;
    do @(posedge clk); while (in_stall);
    want = predict_mix(mute_shadow, s);
    if (typed) want.mix = typed_mix;
    pending_mixes.push_back(want);
    samples_sent++;
  endtask

  // Output stall: random per cycle, or a long hold when one is requested.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_tokens != hold_seen) begin
        hold_seen = hold_tokens;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    mix_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mixes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result mix=%0d block_end=%0b",
                   out_mix_value, out_block_end_out);
      end else begin
        want = pending_mixes.pop_front();
        mixes_checked++;
        if (out_mix_value !== want.mix || out_block_end_out !== want.blk_end) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d mix exp=%0d act=%0d block_end exp=%0b act=%0b",
                     mixes_checked, want.mix, out_mix_value, want.blk_end,
                     out_block_end_out);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final check.
  initial begin
    sample_t           s;
    logic [MASK_W-1:0] mask;
    int                r, ph, sub, k;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_valid          = 1'b0;
    in_pulse_one      = '0;
    in_pulse_two      = '0;
    in_triangle_level = '0;
    in_noise_level    = '0;
    in_delta_level    = '0;
    in_block_end      = 1'b0;
    mute_shadow       = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_tokens       = 0;
    samples_sent      = 0;
    mixes_checked     = 0;
    mismatch_count    = 0;
    mask_writes       = 0;

    // Mask, p1, p2, triangle, noise, delta, block end, typed, mix.
    dir_rows = '{
      '{5'd0,  '{4'd0,  4'd0,  4'd0,  4'd0,  7'd0,   1'b0}, 1'b1, 16'd0},
      '{5'd0,  '{4'd0,  4'd0,  4'd0,  4'd0,  7'd0,   1'b1}, 1'b1, 16'd0},
      '{5'd0,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b1}, 1'b0, 16'd0},
      '{5'd0,  '{4'd15, 4'd0,  4'd0,  4'd0,  7'd0,   1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd0,  4'd15, 4'd0,  4'd0,  7'd0,   1'b1}, 1'b0, 16'd0},
      '{5'd0,  '{4'd0,  4'd0,  4'd15, 4'd0,  7'd0,   1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd0,  4'd0,  4'd0,  4'd15, 7'd0,   1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd0,  4'd0,  4'd0,  4'd0,  7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd1,  4'd0,  4'd0,  4'd0,  7'd0,   1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd0,  4'd0,  4'd0,  4'd0,  7'd1,   1'b1}, 1'b0, 16'd0},
      '{5'd0,  '{4'd15, 4'd15, 4'd0,  4'd0,  7'd0,   1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd0,  4'd0,  4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd10, 4'd5,  4'd10, 4'd5,  7'd85,  1'b1}, 1'b0, 16'd0},
      '{5'd0,  '{4'd5,  4'd10, 4'd5,  4'd10, 7'd42,  1'b0}, 1'b0, 16'd0},
      '{5'd31, '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b1}, 1'b1, 16'd0},
      '{5'd1,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd2,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd4,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b1}, 1'b0, 16'd0},
      '{5'd8,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd16, '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd3,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b1}, 1'b0, 16'd0},
      '{5'd28, '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0},
      '{5'd0,  '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127, 1'b0}, 1'b0, 16'd0}
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows; the mask is rewritten only when a row changes it.
    write_mute_mask('0);
    for (r = 0; r < N_DIRECTED; r++) begin
      if (dir_rows[r].mask != mute_shadow) write_mute_mask(dir_rows[r].mask);
      issue_sample(dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].mix);
    end

    // Random phases: free flow, idle sender, stalling receiver, both, and
    // a long receiver hold that backs the pipeline up into in_stall.
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 83; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 83; end
        3:       begin idle_pct = 20; stall_pct = 20; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (sub = 0; sub < SUBS_PER_PH; sub++) begin
        case ($urandom_range(5))
          0:       mask = '0;
          1:       mask = '1;
          default: mask = MASK_W'($urandom_range(31));
        endcase
        if (ph == 0 && sub == 0) mask = '0;
        if (ph == 3 && sub == 0) mask = '1;
        write_mute_mask(mask);
        if (ph == N_PHASES - 1) hold_tokens++;
        for (k = 0; k < ITEMS_PER_SUB; k++) begin
          s = random_sample();
          issue_sample(s, 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Let the pipeline empty, then keep watching for stray results.
    drain_results(DRAIN_LIMIT);
    if (pending_mixes.size() != 0) begin
      mismatch_count++;
      $display("ERROR: %0d expected results never arrived", pending_mixes.size());
    end
    repeat (LATENCY + 5) @(posedge clk);

    $display("Sent %0d sample requests under %0d mute mask settings, checked %0d results.",
             samples_sent, mask_writes, mixes_checked);
    $display("Idling covered free flow, idle sender, stalled receiver, both, and a long hold.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Failures: %0d", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/amix_pkg.sv
src/amix_prep.sv
src/amix_cell.sv
src/amix_out.sv
src/apu_nonlinear_mixer_top.sv
dv/apu_nonlinear_mixer_top_tb.sv
